[hdl/takf_pkg.sv]
// Shared widths, constants and reset values for the two-axis Kalman smoother.
package takf_pkg;

	localparam int DATA_W    = 32;           // estimate, measurement, registers
	localparam int DEN_W     = DATA_W + 1;   // err + measure uncertainty, exact
	localparam int REM_W     = DEN_W + 1;    // divider partial remainder
	localparam int GAIN_W    = 16;           // unsigned Q0.16 gain
	localparam int QUO_W     = GAIN_W + 1;   // raw quotient, may reach 1.0
	localparam int DIV_CNT_W = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

	localparam int MUL_W  = DATA_W + 1;      // signed operand width
	localparam int PROD_W = 2 * MUL_W;

	localparam int IDX_W = 1;
	localparam logic [IDX_W-1:0] REG_MEAS_UNC   = 1'd0;
	localparam logic [IDX_W-1:0] REG_PROC_NOISE = 1'd1;

	localparam logic [DATA_W-1:0] RST_MEAS_UNC   = 32'd3277;
	localparam logic [DATA_W-1:0] RST_PROC_NOISE = 32'd655;
	localparam logic [DATA_W-1:0] RST_ERR_EST    = 32'd3277;

	localparam logic [QUO_W-1:0] Q_ONE = 17'h10000;

endpackage

[hdl/takf_div.sv]
// Restoring divider: gain = floor(dividend * 2^16 / divisor), one quotient bit per cycle.
module takf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [takf_pkg::DATA_W-1:0]   dividend,
	input  logic [takf_pkg::DEN_W-1:0]    divisor,
	output logic                          done,
	output logic [takf_pkg::GAIN_W-1:0]   gain
);
	import takf_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [REM_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 zero_q;

	logic             ge;
	logic [REM_W-1:0] rem_nxt;

	assign ge      = rem_q >= {1'b0, den_q};
	assign rem_nxt = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder stays below the divisor, so the shift never drops a set bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= REM_W'(dividend);
			den_q  <= divisor;
			zero_q <= (divisor == '0);
			quo_q  <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[QUO_W-2:0], ge};
			rem_q <= {rem_nxt[REM_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	// quotient of exactly 1.0 clips to the largest Q0.16 gain
	assign gain = zero_q ? '0 : (quo_q[QUO_W-1] ? '1 : quo_q[GAIN_W-1:0]);

endmodule

[hdl/takf_mul.sv]
// Shared signed multiplier with a registered product.
module takf_mul (
	input  logic                         clk,
	input  logic [takf_pkg::MUL_W-1:0]   a,
	input  logic [takf_pkg::MUL_W-1:0]   b,
	output logic [takf_pkg::PROD_W-1:0]  prod
);
	import takf_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'($signed(a) * $signed(b));
	end

	assign prod = prod_q;

endmodule

[hdl/two_axis_scalar_kalman_filter.sv]
// Two-channel scalar Kalman smoother, Q16.16, with shared divider and multiplier.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------------------
//  s_*     | in        | s_tvalid/s_tready | s_tdata: measurement, s_tuser: channel
//  m_*     | out       | m_tvalid/m_tready | m_tdata: estimate
//  wr_*    | in        | wr_en             | wr_index, wr_data
//
// One request passes through the serial divider (one gain bit per cycle),
// makes 3 passes through the shared multiplier, then does the error update,
// the output load and a return to idle.
// s_tready is high only while the sequencer is idle.
// A result waiting in the output register does not stop the next request;
// only the final load waits for the output register to free up.
// Reset (arst_n low) restores registers, estimates and the error estimate.
module two_axis_scalar_kalman_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [takf_pkg::DATA_W-1:0] s_tdata,   // [31:0] measurement
	input  logic                        s_tuser,   // [0] channel select
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [takf_pkg::DATA_W-1:0] m_tdata,   // [31:0] estimate
	input  logic                        wr_en,
	input  logic [takf_pkg::IDX_W-1:0]  wr_index,
	input  logic [takf_pkg::DATA_W-1:0] wr_data
);
	import takf_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV  = 7'b0000010,
		ST_MULD = 7'b0000100,
		ST_EST  = 7'b0001000,
		ST_MULQ = 7'b0010000,
		ST_ERR  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [DATA_W-1:0]   meas_unc_q;
	logic [DATA_W-1:0]   proc_noise_q;
	logic [DATA_W-1:0]   est_x_q;
	logic [DATA_W-1:0]   est_y_q;
	logic [DATA_W-1:0]   err_q;
	logic                chan_q;
	logic [DATA_W-1:0]   z_q;
	logic [DATA_W-1:0]   est_q;
	logic [DATA_W-1:0]   mag_q;
	logic [DATA_W-1:0]   t1_q;
	logic [DATA_W-1:0]   out_q;
	logic                m_tvalid_q;

	logic                accept;
	logic                out_load;
	logic                div_done;
	logic [GAIN_W-1:0]   gain;
	logic [DEN_W-1:0]    den;
	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	logic [PROD_W-1:0]   prod;
	logic [DATA_W-1:0]   last;
	logic [DATA_W:0]     diff;
	logic [DATA_W+1:0]   delta;
	logic [DATA_W+1:0]   est_sum;
	logic [DATA_W-1:0]   est_sat;
	logic [DATA_W+1:0]   mag_full;
	logic [47:0]         t2;
	logic [48:0]         err_sum;
	logic [DATA_W-1:0]   err_new;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	assign den = {1'b0, err_q} + {1'b0, meas_unc_q};

	takf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (err_q),
		.divisor  (den),
		.done     (div_done),
		.gain     (gain)
	);

	// operands for gain*diff, (1-gain)*err and |delta|*q in turn
	always_comb begin
		case (state_q)
			ST_MULD: begin
				mul_a = {17'b0, gain};
				mul_b = diff;
			end
			ST_EST: begin
				mul_a = {16'b0, Q_ONE - {1'b0, gain}};
				mul_b = {1'b0, err_q};
			end
			ST_MULQ: begin
				mul_a = {1'b0, mag_q};
				mul_b = {1'b0, proc_noise_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	takf_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign last = chan_q ? est_y_q : est_x_q;
	assign diff = {z_q[DATA_W-1], z_q} - {last[DATA_W-1], last};

	// arithmetic shift of the product floors toward minus infinity
	assign delta   = prod[49:16];
	assign est_sum = {{2{last[DATA_W-1]}}, last} + delta;
	always_comb begin
		if (est_sum[DATA_W+1:DATA_W-1] == 3'b000 || est_sum[DATA_W+1:DATA_W-1] == 3'b111) begin
			est_sat = est_sum[DATA_W-1:0];
		end else if (est_sum[DATA_W+1]) begin
			est_sat = 32'h8000_0000;
		end else begin
			est_sat = 32'h7FFF_FFFF;
		end
	end
	assign mag_full = delta[DATA_W+1] ? (~delta + 1'b1) : delta;

	assign t2      = prod[63:16];
	assign err_sum = {1'b0, t2} + {17'b0, t1_q};
	assign err_new = (|err_sum[48:DATA_W]) ? '1 : err_sum[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			meas_unc_q   <= RST_MEAS_UNC;
			proc_noise_q <= RST_PROC_NOISE;
			est_x_q      <= '0;
			est_y_q      <= '0;
			err_q        <= RST_ERR_EST;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_MEAS_UNC:   meas_unc_q   <= wr_data;
					REG_PROC_NOISE: proc_noise_q <= wr_data;
					default: ;
				endcase
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_MULD;
				end
				ST_MULD: state_q <= ST_EST;
				ST_EST: begin
					if (chan_q) begin
						est_y_q <= est_sat;
					end else begin
						est_x_q <= est_sat;
					end
					state_q <= ST_MULQ;
				end
				ST_MULQ: state_q <= ST_ERR;
				ST_ERR: begin
					err_q   <= err_new;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chan_q <= s_tuser;
			z_q    <= s_tdata;
		end
		if (state_q == ST_EST) begin
			est_q <= est_sat;
			mag_q <= mag_full[DATA_W-1:0];
		end
		if (state_q == ST_MULQ) begin
			t1_q <= prod[47:16];
		end
		if (out_load) begin
			out_q <= est_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while a previous one is in flight");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide phase");

	a_err_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(err_q) |-> ($past(state_q) == ST_ERR))
		else $error("error estimate changed outside its update step");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_FIN))
		else $error("result raised without finishing an update");

endmodule
